[rtl/bandwidth_reservation_admission_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bandwidth reservation admission block
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BANDWIDTH_RESERVATION_ADMISSION_DEFINES_SVH
`define BANDWIDTH_RESERVATION_ADMISSION_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BRA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/bra_pkg.sv]
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants and status codes of the reservation admission block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

	// reservation window in time units, measured from the current time
	localparam int unsigned WINDOW = 4096;
	// advance results with new_time below this count report the first bucket
	localparam int unsigned BUCKET = 16;

	localparam int unsigned STATUS_W = 3;
	typedef logic [STATUS_W-1:0] status_t;

	localparam status_t STATUS_DONE         = 3'd0;
	localparam status_t STATUS_WINDOW       = 3'd1;
	localparam status_t STATUS_CAPACITY     = 3'd2;
	localparam status_t STATUS_NOT_LATER    = 3'd3;
	localparam status_t STATUS_FIRST_BUCKET = 3'd4;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

endpackage

`default_nettype wire

[rtl/bra_req_if.sv]
// ----------------------------------------------------------------------------
// bra_req_if
// Request channel: reserve or advance words with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bra_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] start_offset;
	logic [15:0] duration;
	logic [31:0] bandwidth;
	logic [31:0] new_time;

	modport source (
		output valid, cmd, start_offset, duration, bandwidth, new_time,
		input  ready
	);
	modport sink (
		input  valid, cmd, start_offset, duration, bandwidth, new_time,
		output ready
	);
endinterface

`default_nettype wire

[rtl/bra_rsp_if.sv]
// ----------------------------------------------------------------------------
// bra_rsp_if
// Response channel: one ok/status word per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bra_rsp_if;
	logic                    valid;
	logic                    ready;
	logic                    ok;
	bra_pkg::status_t        status;

	modport source (
		output valid, ok, status,
		input  ready
	);
	modport sink (
		input  valid, ok, status,
		output ready
	);
endinterface

`default_nettype wire

[rtl/bra_rem.sv]
// ----------------------------------------------------------------------------
// bra_rem
// Slot index register: the low bits of a time value, which are its remainder
// by the power-of-two ring depth, captured with a done pulse in the cycle after start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bra_rem #(
	parameter int unsigned DIVISOR = 8192
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [$clog2(DIVISOR)-1:0]   dividend,
	output logic                              done,
	output logic [$clog2(DIVISOR)-1:0]        rem
);

	localparam int unsigned SW = $clog2(DIVISOR);

	logic [SW-1:0] rem_q;
	logic          done_q;

	// done pulse in the cycle after start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	// capture the slot index
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

[rtl/bra_ring.sv]
// ----------------------------------------------------------------------------
// bra_ring
// Usage ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bra_ring #(
	parameter int unsigned DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [31:0]              wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [31:0]                   rdata
);

	logic [31:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/bandwidth_reservation_admission.sv]
// ----------------------------------------------------------------------------
// bandwidth_reservation_admission
// Advance-reservation admission control over a sliding window of time slots.
// ----------------------------------------------------------------------------
//
//  channel | dir | words                                           | handshake
//  --------+-----+-------------------------------------------------+----------
//  req     | in  | cmd, start_offset, duration, bandwidth, new_time | valid/ready
//  rsp     | out | ok, status                                       | valid/ready
//  cfg     | in  | capacity                                         | cfg_wr_en
//
//  After reset the ring is cleared one slot a cycle; no req is taken meanwhile.
//  Zero duration, out of window or time not later: straight to S_DONE, and the
//  rsp word is posted once the rsp register is free. Reserve otherwise: the start
//  slot (S_MOD), then check and update passes (S_CHK, S_UPD) over the single ring
//  read port, then S_DONE to post the word; a capacity refusal ends early.
//  Advance: min(new_time - time, RING_DEPTH) clearing writes (S_ZERO), then S_MOD and S_DONE.
//  req is taken one word at a time; a finished word waits in the rsp register.
//
`timescale 1ns / 1ps
`default_nettype none
`include "bandwidth_reservation_admission_defines.svh"

module bandwidth_reservation_admission #(
	// power of two: a slot is the low bits of a time value
	parameter int unsigned RING_DEPTH = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	bra_req_if.sink          req,
	bra_rsp_if.source        rsp
);

	localparam int unsigned SW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(RING_DEPTH + 1);

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MOD  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_ZERO = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]             state_q;
	logic [SW-1:0]          ptr_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          lim_q;
	logic [15:0]            iss_q;
	logic                   pipe_v_s1;
	logic [SW-1:0]          pipe_addr_s1;
	logic                   cmd_q;
	logic [15:0]            dur_q;
	logic [31:0]            bw_q;
	logic [31:0]            nt_q;
	logic [SW-1:0]          start_slot_q;
	logic [31:0]            cur_q;
	logic [SW-1:0]          cur_slot_q;
	logic [31:0]            cap_q;
	logic                   res_ok_q;
	bra_pkg::status_t       res_status_q;
	logic                   rsp_valid_q;
	logic                   rsp_ok_q;
	bra_pkg::status_t       rsp_status_q;

	logic                   accept;
	logic                   out_free;
	logic [SW-1:0]          ptr_inc;
	logic [CW-1:0]          cnt_inc;
	logic                   zero_last;
	logic [16:0]            win_sum;
	logic                   out_win;
	logic [31:0]            span;
	logic [CW-1:0]          span_lim;
	logic                   issue;
	logic [32:0]            sum_use;
	logic                   cap_fail;
	logic                   mem_we;
	logic [SW-1:0]          mem_waddr;
	logic [31:0]            mem_wdata;
	logic [31:0]            mem_rdata;
	logic                   rem_start;
	logic [SW-1:0]          rem_div;
	logic                   rem_done;
	logic [SW-1:0]          rem_val;

	// handshake and slot pointer arithmetic
	always_comb begin
		accept    = req.valid && (state_q == S_IDLE);
		out_free  = !rsp_valid_q || rsp.ready;
		ptr_inc   = (ptr_q == SW'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
		cnt_inc   = cnt_q + 1'b1;
		zero_last = (cnt_inc == lim_q);
		win_sum   = {1'b0, req.start_offset} + {1'b0, req.duration};
		out_win   = win_sum > 17'(bra_pkg::WINDOW);
		span      = req.new_time - cur_q;
		span_lim  = (span > 32'(RING_DEPTH)) ? CW'(RING_DEPTH) : CW'(span);
	end

	// check and update passes
	always_comb begin
		issue    = ((state_q == S_CHK) || (state_q == S_UPD)) && (iss_q != dur_q);
		sum_use  = {1'b0, mem_rdata} + {1'b0, bw_q};
		cap_fail = (state_q == S_CHK) && pipe_v_s1 && (sum_use > {1'b0, cap_q});
	end

	// ring write port: clear passes write zero, update pass writes usage plus bandwidth
	always_comb begin
		mem_we    = (state_q == S_INIT) || (state_q == S_ZERO) ||
		            ((state_q == S_UPD) && pipe_v_s1);
		mem_waddr = (state_q == S_UPD) ? pipe_addr_s1 : ptr_q;
		mem_wdata = (state_q == S_UPD) ? sum_use[31:0] : '0;
	end

	// slot unit requests: start slot of a reserve, new slot after an advance
	always_comb begin
		rem_start = (accept && (req.cmd == bra_pkg::CMD_RESERVE) &&
		             (req.duration != '0) && !out_win) ||
		            ((state_q == S_ZERO) && zero_last);
		if (state_q == S_IDLE) begin
			rem_div = cur_slot_q + SW'(req.start_offset);
		end else begin
			rem_div = nt_q[SW-1:0];
		end
	end

	bra_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (ptr_q),
		.rdata (mem_rdata)
	);

	bra_rem #(
		.DIVISOR (RING_DEPTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_div),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			ptr_q      <= '0;
			cnt_q      <= '0;
			lim_q      <= CW'(RING_DEPTH);
			iss_q      <= '0;
			pipe_v_s1  <= 1'b0;
			cur_q      <= '0;
			cur_slot_q <= '0;
		end else begin
			// mark a ring read in flight unless the check just failed
			pipe_v_s1 <= issue && !cap_fail;
			case (state_q)
				S_INIT: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_inc;
					if (zero_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == bra_pkg::CMD_RESERVE) begin
							if ((req.duration == '0) || out_win) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_MOD;
							end
						end else begin
							if (req.new_time <= cur_q) begin
								state_q <= S_DONE;
							end else begin
								ptr_q   <= cur_slot_q;
								cnt_q   <= '0;
								lim_q   <= span_lim;
								state_q <= S_ZERO;
							end
						end
					end
				end
				S_ZERO: begin
					ptr_q <= ptr_inc;
					cnt_q <= cnt_inc;
					if (zero_last) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (rem_done) begin
						if (cmd_q == bra_pkg::CMD_RESERVE) begin
							ptr_q   <= rem_val;
							iss_q   <= '0;
							state_q <= S_CHK;
						end else begin
							cur_q      <= nt_q;
							cur_slot_q <= rem_val;
							state_q    <= S_DONE;
						end
					end
				end
				S_CHK: begin
					if (cap_fail) begin
						state_q <= S_DONE;
					end else if ((iss_q == dur_q) && !pipe_v_s1) begin
						ptr_q   <= start_slot_q;
						iss_q   <= '0;
						state_q <= S_UPD;
					end else if (issue) begin
						ptr_q <= ptr_inc;
						iss_q <= iss_q + 1'b1;
					end
				end
				S_UPD: begin
					if ((iss_q == dur_q) && !pipe_v_s1) begin
						state_q <= S_DONE;
					end else if (issue) begin
						ptr_q <= ptr_inc;
						iss_q <= iss_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, result codes and pipeline address
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			dur_q <= req.duration;
			bw_q  <= req.bandwidth;
			nt_q  <= req.new_time;
			if (req.cmd == bra_pkg::CMD_RESERVE) begin
				res_ok_q     <= !out_win || (req.duration == '0);
				res_status_q <= out_win && (req.duration != '0) ?
				                bra_pkg::STATUS_WINDOW : bra_pkg::STATUS_DONE;
			end else begin
				res_ok_q     <= 1'b0;
				res_status_q <= bra_pkg::STATUS_NOT_LATER;
			end
		end
		if ((state_q == S_MOD) && rem_done) begin
			if (cmd_q == bra_pkg::CMD_RESERVE) begin
				start_slot_q <= rem_val;
			end else if (nt_q < 32'(bra_pkg::BUCKET)) begin
				res_ok_q     <= 1'b0;
				res_status_q <= bra_pkg::STATUS_FIRST_BUCKET;
			end else begin
				res_ok_q     <= 1'b1;
				res_status_q <= bra_pkg::STATUS_DONE;
			end
		end
		if (cap_fail) begin
			res_ok_q     <= 1'b0;
			res_status_q <= bra_pkg::STATUS_CAPACITY;
		end
		if ((state_q == S_UPD) && (iss_q == dur_q) && !pipe_v_s1) begin
			res_ok_q     <= 1'b1;
			res_status_q <= bra_pkg::STATUS_DONE;
		end
		if (issue) begin
			pipe_addr_s1 <= ptr_q;
		end
	end

	// response register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			rsp_ok_q     <= res_ok_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.ok     = rsp_ok_q;
	assign rsp.status = rsp_status_q;

	// checks
	`BRA_ASSERT_IMPL(a_idle_no_write, clk, arst_n, state_q == S_IDLE, !mem_we, "ring write while idle")
	`BRA_ASSERT_IMPL(a_pipe_in_pass, clk, arst_n, pipe_v_s1, (state_q == S_CHK) || (state_q == S_UPD), "read pipe live outside a pass")
	`BRA_ASSERT_NEXT(a_slot_one_cycle, clk, arst_n, rem_start, rem_done, "slot unit missed its result")
	`BRA_ASSERT_NEXT(a_mod_to_chk, clk, arst_n, (state_q == S_MOD) && rem_done && (cmd_q == bra_pkg::CMD_RESERVE), state_q == S_CHK, "reserve did not enter check pass")

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks bandwidth_reservation_admission against a behavioral predictor of
// the usage ring and the current time. A directed table covers window edges,
// capacity edges, zero duration, stale time, the first bucket and full-ring
// advances, and then random words run under several capacity settings. Both
// sides idle at random, and the response side holds off once for a long
// stretch. Every response word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
	import bra_pkg::*;

	localparam int unsigned RING = 8192;
	localparam int unsigned RING_W = $clog2(RING);
	localparam int unsigned RANDOM_PER_PHASE = 25;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int ROW_COUNT = 23;
	// rows from here on run at the top of the time range, after the random part
	localparam int TOP_FIRST = 17;
	localparam logic TYPED = 1'b1;
	localparam logic CALC = 1'b0;

	typedef struct packed {
		logic        cmd;
		logic [15:0] start_offset;
		logic [15:0] duration;
		logic [31:0] bandwidth;
		logic [31:0] new_time;
	} request_t;

	typedef struct packed {
		logic    ok;
		status_t status;
	} verdict_t;

	typedef struct packed {
		request_t word;
		logic     typed;
		verdict_t verdict;
	} row_t;

	// word: cmd, offset, duration, bandwidth, new_time / typed or calc / verdict
	row_t rows [ROW_COUNT] = '{
		'{'{CMD_RESERVE, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'd0}, TYPED, '{1'b1, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd0, 16'hFFFF, 32'd1, 32'd0}, TYPED, '{1'b0, STATUS_WINDOW}},
		'{'{CMD_RESERVE, 16'hFFFF, 16'd1, 32'd1, 32'd0}, TYPED, '{1'b0, STATUS_WINDOW}},
		'{'{CMD_RESERVE, 16'd4095, 16'd1, 32'hFFFF_FFFF, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd4095, 16'd1, 32'd1, 32'd0}, TYPED, '{1'b0, STATUS_CAPACITY}},
		'{'{CMD_RESERVE, 16'd0, 16'd4096, 32'd0, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd0}, TYPED, '{1'b0, STATUS_NOT_LATER}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd5}, TYPED, '{1'b0, STATUS_FIRST_BUCKET}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd15}, TYPED, '{1'b0, STATUS_FIRST_BUCKET}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd16}, TYPED, '{1'b1, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd0, 16'd16, 32'h8000_0000, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd8, 16'd16, 32'h8000_0000, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd4080, 16'd16, 32'h7FFF_FFFF, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd4081, 16'd16, 32'd1, 32'd0}, TYPED, '{1'b0, STATUS_WINDOW}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd16}, TYPED, '{1'b0, STATUS_NOT_LATER}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'd8308}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'd100, 16'd8, 32'hFFFF_FFFF, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'hFFFF_FF00}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'h00F0, 16'd32, 32'd5, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_RESERVE, 16'hFFFF, 16'd1, 32'd1, 32'd0}, TYPED, '{1'b0, STATUS_WINDOW}},
		'{'{CMD_RESERVE, 16'h0100, 16'd16, 32'hFFFF_FFFB, 32'd0}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF}, CALC, '{1'b0, STATUS_DONE}},
		'{'{CMD_ADVANCE, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF}, TYPED, '{1'b0, STATUS_NOT_LATER}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	bra_req_if req_ch ();
	bra_rsp_if rsp_ch ();

	// predicted block state
	logic [31:0] slot_usage [RING];
	logic [31:0] now_time;
	logic [31:0] capacity;

	verdict_t pending_verdicts [$];
	int unsigned mismatches = 0;
	// steady: no idling on either side; hold_rsp: ask for one long hold-off
	bit steady = 1'b0;
	bit hold_rsp = 1'b0;

	bandwidth_reservation_admission #(
		.RING_DEPTH(RING)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req_ch),
		.rsp        (rsp_ch)
	);

	always #1 clk = ~clk;

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Apply one accepted word to the predicted state and return its verdict.
	task automatic admit_word(input request_t w, output verdict_t v);
		logic [63:0] first_t;
		logic [63:0] end_t;
		logic [63:0] t;
		logic [63:0] span;
		logic [63:0] limit;
		logic        blocked;
		v = '{1'b1, STATUS_DONE};
		if (w.cmd == CMD_RESERVE) begin
			first_t = {32'd0, now_time} + {48'd0, w.start_offset};
			end_t = first_t + {48'd0, w.duration};
			limit = {32'd0, now_time} + 64'(WINDOW);
			blocked = 1'b0;
			if (w.duration == 16'd0) begin
				v = '{1'b1, STATUS_DONE};
			end else if (end_t > limit) begin
				v = '{1'b0, STATUS_WINDOW};
			end else begin
				// check every slot, then commit only if none overflows
				for (t = first_t; t < end_t; t++)
					if ({32'd0, slot_usage[RING_W'(t % RING)]} + {32'd0, w.bandwidth}
							> {32'd0, capacity})
						blocked = 1'b1;
				if (blocked) begin
					v = '{1'b0, STATUS_CAPACITY};
				end else begin
					for (t = first_t; t < end_t; t++)
						slot_usage[RING_W'(t % RING)] = slot_usage[RING_W'(t % RING)]
							+ w.bandwidth;
				end
			end
		end else if (w.new_time <= now_time) begin
			v = '{1'b0, STATUS_NOT_LATER};
		end else begin
			// zero the passed slots, never more than the whole ring
			span = {32'd0, w.new_time} - {32'd0, now_time};
			if (span > 64'(RING))
				span = 64'(RING);
			for (t = 0; t < span; t++)
				slot_usage[RING_W'(({32'd0, now_time} + t) % RING)] = '0;
			now_time = w.new_time;
			if (w.new_time < BUCKET)
				v = '{1'b0, STATUS_FIRST_BUCKET};
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one word after an optional gap and queue its verdict once taken.
	task automatic send_word(input request_t w, input logic typed, input verdict_t given,
			input int unsigned gap);
		verdict_t calc;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= w.cmd;
		req_ch.start_offset <= w.start_offset;
		req_ch.duration <= w.duration;
		req_ch.bandwidth <= w.bandwidth;
		req_ch.new_time <= w.new_time;
		do @(posedge clk); while (!req_ch.ready);
		admit_word(w, calc);
		pending_verdicts.push_back(typed ? given : calc);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Write capacity only once the block has answered everything.
	task automatic set_capacity(input logic [31:0] value);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity = value;
	endtask

	// Response side: check accepted words, then pick next ready.
	initial begin
		int unsigned quiet_left;
		verdict_t want;
		quiet_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch("response word with nothing pending");
				end else begin
					want = pending_verdicts.pop_front();
					if (rsp_ch.ok !== want.ok)
						report_mismatch($sformatf("ok %b, predicted %b", rsp_ch.ok, want.ok));
					if (rsp_ch.status !== want.status)
						report_mismatch($sformatf("status %0d, predicted %0d",
							rsp_ch.status, want.status));
				end
			end
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				quiet_left = HOLD_CYCLES;
			end else if (!steady && quiet_left == 0 && $urandom_range(0, 199) == 0) begin
				quiet_left = $urandom_range(20, 80);
			end
			if (quiet_left != 0) begin
				quiet_left--;
				rsp_ch.ready <= 1'b0;
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Stimulus: reset, directed table, random phases, top-of-time table.
	initial begin
		request_t w;
		int unsigned r;
		int edge_off;
		int phase;
		int i;
		verdict_t none;
		none = '{1'b0, STATUS_DONE};
		for (i = 0; i < RING; i++)
			slot_usage[i] = '0;
		now_time = '0;
		capacity = 32'hFFFF_FFFF;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_RESERVE;
		req_ch.start_offset <= '0;
		req_ch.duration <= '0;
		req_ch.bandwidth <= '0;
		req_ch.new_time <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_capacity(32'hFFFF_FFFF);
		for (i = 0; i < TOP_FIRST; i++)
			send_word(rows[i].word, rows[i].typed, rows[i].verdict, pick_gap());

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_capacity($urandom_range(1000, 100000));
				1: set_capacity(32'd0);
				2: set_capacity($urandom);
				default: set_capacity(32'hFFFF_FFFF);
			endcase
			// phase 2: no idling, and one long hold-off on the response side
			steady = (phase == 2);
			hold_rsp = (phase == 2);
			for (i = 0; i < RANDOM_PER_PHASE; i++) begin
				w = '0;
				r = $urandom_range(0, 99);
				if (r < 62) begin
					w.cmd = CMD_RESERVE;
					// mostly short intervals, a few long ones
					r = $urandom_range(0, 99);
					if (r < 5)
						w.duration = 16'd0;
					else if (r < 88)
						w.duration = 16'($urandom_range(1, 32));
					else if (r < 95)
						w.duration = 16'($urandom_range(33, 512));
					else if (r < 97)
						w.duration = 16'($urandom_range(513, 4096));
					else
						w.duration = 16'($urandom);
					// near start, on the window edge, or anywhere
					r = $urandom_range(0, 99);
					if (r < 70) begin
						w.start_offset = 16'($urandom_range(0, 200));
					end else if (r < 85 && w.duration <= 16'd4096) begin
						edge_off = 4095 - int'(w.duration) + int'($urandom_range(0, 2));
						w.start_offset = (edge_off < 0) ? 16'd0 : edge_off[15:0];
					end else begin
						w.start_offset = 16'($urandom);
					end
					// fractions of capacity so that overlaps fill slots
					r = $urandom_range(0, 99);
					if (r < 45)
						w.bandwidth = $urandom_range(0, capacity / 3);
					else if (r < 65)
						w.bandwidth = (capacity < 3) ? $urandom_range(0, capacity)
							: capacity - $urandom_range(0, 3);
					else if (r < 80)
						w.bandwidth = 32'd0;
					else if (r < 90)
						w.bandwidth = 32'hFFFF_FFFF;
					else
						w.bandwidth = $urandom;
				end else begin
					w.cmd = CMD_ADVANCE;
					r = $urandom_range(0, 99);
					if (r < 8)
						w.new_time = (now_time >= 16) ? now_time - $urandom_range(0, 16)
							: now_time;
					else if (r < 90)
						w.new_time = now_time + $urandom_range(1, 48);
					else if (r < 97)
						w.new_time = now_time + $urandom_range(49, 1000);
					else
						w.new_time = now_time + $urandom_range(8000, 20000);
				end
				send_word(w, CALC, none, pick_gap());
			end
		end
		steady = 1'b0;

		set_capacity(32'hFFFF_FFFF);
		for (i = TOP_FIRST; i < ROW_COUNT; i++)
			send_word(rows[i].word, rows[i].typed, rows[i].verdict, pick_gap());

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[bandwidth_reservation_admission.f]
+incdir+rtl
rtl/bra_pkg.sv
rtl/bra_req_if.sv
rtl/bra_rsp_if.sv
rtl/bra_rem.sv
rtl/bra_ring.sv
rtl/bandwidth_reservation_admission.sv
test/testbench.sv
